// File: rtl/ddagrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddagrt_pkg
// Shared types and constants of the grid ray walker: request and response
// payloads, controller-to-datapath command bundle, fixed-point formats.
// ----------------------------------------------------------------------------
package ddagrt_pkg;

	// Map and fixed-point formats
	localparam int MAP_BITS  = 8;                 // cells per axis: 2^MAP_BITS
	localparam int FRAC_BITS = 16;                // position / distance fraction bits
	localparam int POS_W     = 24;                // position field width
	localparam int DIR_W     = 16;                // direction field width, Q2.14
	localparam int DIR_FRAC  = 14;                // direction fraction bits
	localparam int DIST_W    = 32;                // span and distance width
	localparam int MAG_W     = DIR_W;             // direction magnitude width

	// Reciprocal: one quotient bit per cycle of 2^(FRAC_BITS+DIR_FRAC) / |dir|
	localparam int DIV_STEPS = FRAC_BITS + DIR_FRAC + 1;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Opcodes
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// Side codes
	localparam logic SIDE_X = 1'b0;
	localparam logic SIDE_Y = 1'b1;

	typedef struct packed {
		logic                    opcode;
		logic [POS_W-1:0]        pos_x;
		logic [POS_W-1:0]        pos_y;
		logic signed [DIR_W-1:0] dir_x;
		logic signed [DIR_W-1:0] dir_y;
	} req_t;

	typedef struct packed {
		logic [MAP_BITS-1:0] cell_x;
		logic [MAP_BITS-1:0] cell_y;
		logic                hit_side;
		logic [DIST_W-1:0]   perp_dist;
	} rsp_t;

	// Controller commands to the datapath
	typedef struct packed {
		logic capture;    // latch request, clear divider; a start also loads cells and signs
		logic div_step;   // one reciprocal iteration on both axes
		logic div_first;  // iteration that brings in the dividend's set bit
		logic ray_load;   // write spans and initial edge distances
		logic start_out;  // write the start response
		logic step_out;   // advance one cell and write its response
	} cmd_t;

endpackage

// File: rtl/ddagrt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddagrt_ctrl
// Sequencer of the grid ray walker: accepts one request at a time, runs the
// reciprocal iterations for a start, and owns the response valid flag.
// ----------------------------------------------------------------------------
module ddagrt_ctrl import ddagrt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  logic req_opcode,
	output logic rsp_valid,
	input  logic rsp_stall,
	output cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_STEP = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]           state_q, state_nxt;
	logic [DIV_CNT_W-1:0] cnt_q, cnt_nxt;
	logic                 rsp_valid_q;
	logic                 req_acc;
	logic                 rsp_free;
	logic                 rsp_write;

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_write = cmd.start_out || cmd.step_out;

	// Sequence one request
	always_comb begin
		state_nxt = state_q;
		cnt_nxt   = cnt_q;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					cmd.capture = 1'b1;
					cnt_nxt     = '0;
					state_nxt   = (req_opcode == OP_STEP) ? S_STEP : S_DIV;
				end
			end
			S_STEP: begin
				if (rsp_free) begin
					cmd.step_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			S_DIV: begin
				cmd.div_step  = 1'b1;
				cmd.div_first = (cnt_q == '0);
				cnt_nxt       = cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_nxt = S_MUL;
				end
			end
			S_MUL: begin
				cmd.ray_load = 1'b1;
				state_nxt    = S_FIN;
			end
			S_FIN: begin
				if (rsp_free) begin
					cmd.start_out = 1'b1;
					state_nxt     = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			cnt_q       <= cnt_nxt;
			// hold while stalled, set on a new response
			rsp_valid_q <= (rsp_valid_q && rsp_stall) || rsp_write;
		end
	end

endmodule

// File: rtl/ddagrt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddagrt_dp
// Datapath of the grid ray walker: ray state, bit-serial reciprocal for both
// axes, initial edge distance multiply, cell step and response register.
// ----------------------------------------------------------------------------
module ddagrt_dp import ddagrt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  req_t req_data,
	input  cmd_t cmd,
	output rsp_t rsp_data
);

	localparam int PROD_W = FRAC_BITS + 1 + DIST_W;

	// Ray state
	logic [MAP_BITS-1:0] cell_x_q, cell_y_q;
	logic                neg_x_q, neg_y_q;
	logic [DIST_W-1:0]   edge_x_q, edge_y_q;
	logic [DIST_W-1:0]   span_x_q, span_y_q;

	// Start operands and reciprocal
	logic [FRAC_BITS-1:0] frac_x_q, frac_y_q;
	logic [MAG_W-1:0]     mag_x_q, mag_y_q;
	logic [MAG_W-1:0]     rem_x_q, rem_y_q;
	logic [DIV_STEPS-1:0] quo_x_q, quo_y_q;

	rsp_t rsp_q;

	logic [MAG_W-1:0]   mag_x_in, mag_y_in;
	logic [MAG_W:0]     div_x, div_y;
	logic [DIST_W-1:0]  span_x_w, span_y_w;
	logic [FRAC_BITS:0] part_x, part_y;
	logic [PROD_W-1:0]  prod_x, prod_y;
	logic [DIST_W:0]    sum_x, sum_y;
	logic [DIST_W-1:0]  sat_x, sat_y;
	logic               take_x;
	logic [DIST_W-1:0]  dist_step;

	// One restoring iteration: returns {new remainder, quotient bit}
	function automatic logic [MAG_W:0] div_iter(input logic [MAG_W-1:0] rem,
			input logic [MAG_W-1:0] mag, input logic lsb);
		logic [MAG_W:0] sh;
		logic [MAG_W:0] diff;
		logic           ge;
		sh   = {rem, lsb};
		diff = sh - {1'b0, mag};
		ge   = (sh >= {1'b0, mag});
		return {(ge ? diff[MAG_W-1:0] : sh[MAG_W-1:0]), ge};
	endfunction

	// Magnitude of the direction components
	assign mag_x_in = req_data.dir_x[DIR_W-1] ? (MAG_W'(0) - req_data.dir_x) : req_data.dir_x;
	assign mag_y_in = req_data.dir_y[DIR_W-1] ? (MAG_W'(0) - req_data.dir_y) : req_data.dir_y;

	assign div_x = div_iter(rem_x_q, mag_x_q, cmd.div_first);
	assign div_y = div_iter(rem_y_q, mag_y_q, cmd.div_first);

	// Span saturates to all ones for a zero component
	assign span_x_w = (mag_x_q == '0) ? '1 : DIST_W'(quo_x_q);
	assign span_y_w = (mag_y_q == '0) ? '1 : DIST_W'(quo_y_q);

	// Fraction to the cell edge in the step direction
	assign part_x = neg_x_q ? {1'b0, frac_x_q} : ({1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac_x_q});
	assign part_y = neg_y_q ? {1'b0, frac_y_q} : ({1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac_y_q});

	assign prod_x = PROD_W'(part_x) * PROD_W'(span_x_w);
	assign prod_y = PROD_W'(part_y) * PROD_W'(span_y_w);

	// Step along the smaller edge distance, ties to y
	assign take_x = (edge_x_q < edge_y_q);
	assign sum_x  = {1'b0, edge_x_q} + {1'b0, span_x_q};
	assign sum_y  = {1'b0, edge_y_q} + {1'b0, span_y_q};
	assign sat_x  = sum_x[DIST_W] ? '1 : sum_x[DIST_W-1:0];
	assign sat_y  = sum_y[DIST_W] ? '1 : sum_y[DIST_W-1:0];

	// New edge minus span: the old edge, or all ones minus span on saturation
	assign dist_step = take_x ? (sum_x[DIST_W] ? ~span_x_q : edge_x_q)
	                          : (sum_y[DIST_W] ? ~span_y_q : edge_y_q);

	// Update ray state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_x_q <= '0;
			cell_y_q <= '0;
			neg_x_q  <= 1'b0;
			neg_y_q  <= 1'b0;
			edge_x_q <= '0;
			edge_y_q <= '0;
			span_x_q <= '0;
			span_y_q <= '0;
		end else begin
			priority if (cmd.capture && (req_data.opcode == OP_START)) begin
				cell_x_q <= req_data.pos_x[FRAC_BITS +: MAP_BITS];
				cell_y_q <= req_data.pos_y[FRAC_BITS +: MAP_BITS];
				neg_x_q  <= req_data.dir_x[DIR_W-1];
				neg_y_q  <= req_data.dir_y[DIR_W-1];
			end else if (cmd.ray_load) begin
				span_x_q <= span_x_w;
				span_y_q <= span_y_w;
				edge_x_q <= prod_x[FRAC_BITS +: DIST_W];
				edge_y_q <= prod_y[FRAC_BITS +: DIST_W];
			end else if (cmd.step_out) begin
				if (take_x) begin
					edge_x_q <= sat_x;
					cell_x_q <= neg_x_q ? (cell_x_q - MAP_BITS'(1)) : (cell_x_q + MAP_BITS'(1));
				end else begin
					edge_y_q <= sat_y;
					cell_y_q <= neg_y_q ? (cell_y_q - MAP_BITS'(1)) : (cell_y_q + MAP_BITS'(1));
				end
			end
		end
	end

	// Latch start operands and iterate the reciprocal
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			frac_x_q <= req_data.pos_x[FRAC_BITS-1:0];
			frac_y_q <= req_data.pos_y[FRAC_BITS-1:0];
			mag_x_q  <= mag_x_in;
			mag_y_q  <= mag_y_in;
			rem_x_q  <= '0;
			rem_y_q  <= '0;
			quo_x_q  <= '0;
			quo_y_q  <= '0;
		end else if (cmd.div_step) begin
			rem_x_q  <= div_x[MAG_W:1];
			rem_y_q  <= div_y[MAG_W:1];
			quo_x_q  <= {quo_x_q[DIV_STEPS-2:0], div_x[0]};
			quo_y_q  <= {quo_y_q[DIV_STEPS-2:0], div_y[0]};
		end
	end

	// Response register
	always_ff @(posedge clk) begin
		if (cmd.start_out) begin
			rsp_q.cell_x    <= cell_x_q;
			rsp_q.cell_y    <= cell_y_q;
			rsp_q.hit_side  <= SIDE_X;
			rsp_q.perp_dist <= '0;
		end else if (cmd.step_out) begin
			rsp_q.cell_x    <= take_x ? (neg_x_q ? (cell_x_q - MAP_BITS'(1))
			                                     : (cell_x_q + MAP_BITS'(1))) : cell_x_q;
			rsp_q.cell_y    <= take_x ? cell_y_q : (neg_y_q ? (cell_y_q - MAP_BITS'(1))
			                                                : (cell_y_q + MAP_BITS'(1)));
			rsp_q.hit_side  <= take_x ? SIDE_X : SIDE_Y;
			rsp_q.perp_dist <= dist_step;
		end
	end

	assign rsp_data = rsp_q;

endmodule

// File: rtl/dda_grid_ray_traversal_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_grid_ray_traversal_unit
// Grid ray walker: a start request loads a ray from position and direction,
// each step request moves one map cell; every request returns one response.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------
//  req     | in        | req_valid / req_stall | req_data  (req_t)
//  rsp     | out       | rsp_valid / rsp_stall | rsp_data  (rsp_t)
//
//  A step request is accepted, then the cell update and response write follow.
//  A start request runs the bit-serial reciprocal (both axes in parallel),
//  then the multiply and the response write.
//  The response register decouples the sides: a new request is accepted while
//  an earlier response still waits; a stalled response holds only the write.
//  Reset clears the ray state to zero and leaves no response pending.
//
module dda_grid_ray_traversal_unit import ddagrt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_data
);

	cmd_t cmd;

	ddagrt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_opcode (req_data.opcode),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.cmd        (cmd)
	);

	ddagrt_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req_data),
		.cmd      (cmd),
		.rsp_data (rsp_data)
	);

endmodule

// File: rtl/ddagrt_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddagrt_chk
// Port-level checks of the grid ray walker, bound to the top level.
// ----------------------------------------------------------------------------
module ddagrt_chk import ddagrt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req_data,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp_data
);

	// Hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("stalled response dropped or changed");

	// Block new requests after a start is accepted
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req_data.opcode == OP_START) |=> req_stall ##1 req_stall)
		else $error("request accepted during reciprocal");

	// Deliver a step response after accept when the output is free
	a_step_lat: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req_data.opcode == OP_STEP) ##1
		(!rsp_valid || !rsp_stall) |=> rsp_valid)
		else $error("step response late");

	// Take only one request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("back-to-back request accepted");

endmodule

bind dda_grid_ray_traversal_unit ddagrt_chk u_chk (.*);

// File: dv/ray_walk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_walk_checker
// Watches both channels of the grid ray walker. Each accepted request updates
// a local copy of the ray state and queues the response it should produce;
// each accepted response is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module ray_walk_checker import ddagrt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req_data,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp_data,
	output int   mismatches,
	output int   pending
);

	localparam logic [DIST_W-1:0] DIST_SAT = '1;

	// Ray state as the block should hold it
	logic [MAP_BITS-1:0] cell_x, cell_y;
	logic                neg_x, neg_y;
	logic [DIST_W-1:0]   edge_x, edge_y;
	logic [DIST_W-1:0]   span_x, span_y;
	logic                side;

	rsp_t expected_rsps[$];

	// Cell span: 2^(FRAC_BITS+DIR_FRAC) / |dir|, all ones for a zero component
	function automatic logic [DIST_W-1:0] recip_span(input logic signed [DIR_W-1:0] dir);
		logic [DIR_W:0] mag;
		logic [63:0]    quot;
		mag = (dir < 0) ? (DIR_W+1)'(-int'(dir)) : (DIR_W+1)'(int'(dir));
		if (mag == 0)
			return DIST_SAT;
		quot = (64'd1 << (FRAC_BITS + DIR_FRAC)) / 64'(mag);
		return (quot > 64'(DIST_SAT)) ? DIST_SAT : quot[DIST_W-1:0];
	endfunction

	function automatic logic [DIST_W-1:0] sat_sum(input logic [DIST_W-1:0] a,
			input logic [DIST_W-1:0] b);
		logic [DIST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DIST_W] ? DIST_SAT : s[DIST_W-1:0];
	endfunction

	// Load one axis of a new ray from its position and direction
	function automatic void load_axis(input logic [POS_W-1:0] pos,
			input logic signed [DIR_W-1:0] dir, output logic [MAP_BITS-1:0] grid_cell,
			output logic neg, output logic [DIST_W-1:0] start_dist,
			output logic [DIST_W-1:0] span);
		logic [FRAC_BITS:0] part;
		logic [63:0]        prod;
		grid_cell = MAP_BITS'(pos >> FRAC_BITS);
		span = recip_span(dir);
		neg  = dir[DIR_W-1];
		part = neg ? {1'b0, pos[FRAC_BITS-1:0]}
			: (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, pos[FRAC_BITS-1:0]};
		prod = 64'(part) * 64'(span);
		start_dist = prod[FRAC_BITS +: DIST_W];
	endfunction

	// Apply one request to the ray state and return its response
	function automatic rsp_t walk_ray(input req_t r);
		rsp_t              res;
		logic [DIST_W-1:0] reached, crossed_span;
		if (r.opcode == OP_START) begin
			load_axis(r.pos_x, r.dir_x, cell_x, neg_x, edge_x, span_x);
			load_axis(r.pos_y, r.dir_y, cell_y, neg_y, edge_y, span_y);
			side         = SIDE_X;
			reached      = '0;
			crossed_span = '0;
		end else if (edge_x < edge_y) begin
			edge_x       = sat_sum(edge_x, span_x);
			cell_x       = neg_x ? cell_x - 1'b1 : cell_x + 1'b1;
			side         = SIDE_X;
			reached      = edge_x;
			crossed_span = span_x;
		end else begin
			// a tie goes to y
			edge_y       = sat_sum(edge_y, span_y);
			cell_y       = neg_y ? cell_y - 1'b1 : cell_y + 1'b1;
			side         = SIDE_Y;
			reached      = edge_y;
			crossed_span = span_y;
		end
		res.cell_x    = cell_x;
		res.cell_y    = cell_y;
		res.hit_side  = side;
		res.perp_dist = (reached >= crossed_span) ? reached - crossed_span : '0;
		return res;
	endfunction

	task automatic check_field(input string name, input logic [DIST_W-1:0] want,
			input logic [DIST_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// Pop and compare responses, then queue the prediction for each request
	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			cell_x     = '0;
			cell_y     = '0;
			neg_x      = 1'b0;
			neg_y      = 1'b0;
			edge_x     = '0;
			edge_y     = '0;
			span_x     = '0;
			span_y     = '0;
			side       = SIDE_X;
			mismatches = 0;
			expected_rsps.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected response, expected none, got %p", $time,
						rsp_data);
				end else begin
					want = expected_rsps.pop_front();
					check_field("cell_x", want.cell_x, rsp_data.cell_x);
					check_field("cell_y", want.cell_y, rsp_data.cell_y);
					check_field("hit_side", want.hit_side, rsp_data.hit_side);
					check_field("perp_dist", want.perp_dist, rsp_data.perp_dist);
				end
			end
			if (req_valid && !req_stall)
				expected_rsps.push_back(walk_ray(req_data));
		end
		pending = expected_rsps.size();
	end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the grid ray walker with a directed opening (reset-state steps, zero
// and extreme directions, map wrap, distance saturation) and then random rays,
// each a start followed by a run of steps, with random idling on both sides
// and one long response hold-off. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	import ddagrt_pkg::*;

	localparam int N_ITEMS      = 1300;
	localparam int QUIET_FROM   = 1150;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data  = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;
	int   mismatches;
	int   pending;
	int   sent      = 0;
	bit   quiet     = 1'b0;

	dda_grid_ray_traversal_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	ray_walk_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_data   (req_data),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_data   (rsp_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic req_t start_req(input logic [POS_W-1:0] px,
			input logic [POS_W-1:0] py, input logic signed [DIR_W-1:0] dx,
			input logic signed [DIR_W-1:0] dy);
		req_t r;
		r.opcode = OP_START;
		r.pos_x  = px;
		r.pos_y  = py;
		r.dir_x  = dx;
		r.dir_y  = dy;
		return r;
	endfunction

	// Step requests carry random unused fields
	function automatic req_t step_req();
		req_t r;
		r.opcode = OP_STEP;
		r.pos_x  = POS_W'($urandom);
		r.pos_y  = POS_W'($urandom);
		r.dir_x  = DIR_W'($urandom);
		r.dir_y  = DIR_W'($urandom);
		return r;
	endfunction

	function automatic logic [POS_W-1:0] rand_pos();
		logic [POS_W-1:0] p;
		p = POS_W'($urandom);
		case ($urandom_range(0, 7))
			0: p[FRAC_BITS-1:0] = '0;
			1: p[FRAC_BITS-1:0] = '1;
			default: ;
		endcase
		return p;
	endfunction

	// Bias toward zero, extreme and tiny components
	function automatic logic signed [DIR_W-1:0] rand_dir();
		logic signed [DIR_W-1:0] d;
		case ($urandom_range(0, 9))
			0: d = '0;
			1: d = {1'b1, {(DIR_W-1){1'b0}}};
			2: d = {1'b0, {(DIR_W-1){1'b1}}};
			3: begin
				d = DIR_W'($urandom_range(1, 4));
				if ($urandom_range(0, 1))
					d = -d;
			end
			default: d = DIR_W'($urandom);
		endcase
		return d;
	endfunction

	// Offer one request, maybe after an idle burst; return at its accepting edge
	task automatic send_req(input req_t r);
		bit stalled;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		do begin
			@(negedge clk);
			stalled = req_stall;
			@(posedge clk);
		end while (stalled);
		sent++;
	endtask

	// Response side: random stall bursts, one long hold-off, none at the end
	initial begin : receiver
		bit held;
		held = 1'b0;
		@(posedge clk);
		forever begin
			if (!held && sent >= HOLD_AT) begin
				held = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (quiet || $urandom_range(0, 3) != 0) begin
				rsp_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int steps;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk from the reset state
		send_req(step_req());
		send_req(step_req());
		// zero direction on both axes: saturated spans
		send_req(start_req(24'h000000, 24'h000000, 16'sh0000, 16'sh0000));
		repeat (2) send_req(step_req());
		// most negative direction from the origin: wrap below cell zero
		send_req(start_req(24'h000000, 24'h000000, 16'sh8000, 16'sh8000));
		repeat (2) send_req(step_req());
		// most positive direction from the top corner: wrap past the last cell
		send_req(start_req(24'hFFFFFF, 24'hFFFFFF, 16'sh7FFF, 16'sh7FFF));
		repeat (2) send_req(step_req());
		// unit direction along x only
		send_req(start_req(24'h008000, 24'h108000, 16'sh4000, 16'sh0000));
		repeat (2) send_req(step_req());
		// tiny direction: distance saturates, then the tie goes to y
		send_req(start_req(24'h00FFFF, 24'h000000, 16'sh0001, 16'sh0000));
		repeat (6) send_req(step_req());
		// minus one on x, a negative direction on y
		send_req(start_req(24'h7F0001, 24'h80FFFF, 16'shFFFF, 16'shC000));
		repeat (2) send_req(step_req());

		// random rays, with stale-ray step bursts as noise
		while (sent < N_ITEMS) begin
			if (sent >= QUIET_FROM)
				quiet = 1'b1;
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4)) send_req(step_req());
			end else begin
				send_req(start_req(rand_pos(), rand_pos(), rand_dir(), rand_dir()));
				steps = $urandom_range(0, 24);
				repeat (steps) send_req(step_req());
			end
		end
		req_valid <= 1'b0;

		// drain outstanding responses, then watch for strays
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
